[src/kms_pkg.sv]
// Shared types and constants for the keyed multi-stack store.
// No dependencies; every other file imports this package.
package kms_pkg;

    localparam int SEC_FW = 3;
    localparam int ID_W   = 16;
    localparam int ST_W   = 2;

    typedef enum logic [ST_W-1:0] {
        ST_STORED    = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        OP_STORE    = 1'b0,
        OP_RETRIEVE = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              sec_ok;
        logic [SEC_FW-1:0] sec;
        logic [ID_W-1:0]   id;
    } t_cmd;

endpackage

[src/kms_if.sv]
// Valid/ready channel interfaces for request and result transfers.
// Depends on kms_pkg for field widths.
interface kms_in_if import kms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SEC_FW-1:0] section;
    logic [ID_W-1:0]   package_id;

    modport source (output valid, output operation, output section, output package_id,
                    input ready);
    modport sink   (input valid, input operation, input section, input package_id,
                    output ready);
endinterface

interface kms_out_if import kms_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] found_id;

    modport source (output valid, output status, output found_id, input ready);
    modport sink   (input valid, input status, input found_id, output ready);
endinterface

[src/kms_front.sv]
// Front end: registers each request transfer and classifies it.
// Depends on kms_pkg and kms_in_if.
module kms_front import kms_pkg::*; #(
    parameter int NUM_SECTIONS = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    kms_in_if.sink i_in,
    output logic   o_valid,
    output t_cmd   o_cmd,
    input  logic   i_ready
);

    logic r_vld;
    t_cmd r_cmd;
    logic w_sec_ok;

    assign w_sec_ok   = {4'b0, i_in.section} < 7'(NUM_SECTIONS);
    assign i_in.ready = !r_vld || i_ready;
    assign o_valid    = r_vld;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
            if (i_in.valid) begin
                r_cmd.op     <= t_op'(i_in.operation);
                r_cmd.sec_ok <= w_sec_ok;
                r_cmd.sec    <= i_in.section;
                r_cmd.id     <= i_in.package_id;
            end
        end
    end

endmodule

[src/kms_fifo.sv]
// Two-entry command queue between the front end and the stack engine.
// Depends on kms_pkg for the command type.
module kms_fifo import kms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_ready
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[src/kms_back.sv]
// Stack engine: section counts, entry memory, scan and shift sequencer,
// and the result register. Depends on kms_pkg and kms_out_if.
module kms_back import kms_pkg::*; #(
    parameter int NUM_SECTIONS = 8,
    parameter int STACK_DEPTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_ready,
    kms_out_if.source o_out
);

    localparam int SEC_W  = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int MEM_D  = NUM_SECTIONS * STACK_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [CNT_W-1:0] r_cnt [NUM_SECTIONS];
    logic [ID_W-1:0] r_mem [MEM_D];
    logic [ID_W-1:0] r_rdata;

    logic [SEC_W-1:0]  r_sec;
    logic [ADDR_W-1:0] r_base;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_n;
    logic [ID_W-1:0]   r_id;
    t_status           r_status;
    logic [ID_W-1:0]   r_found;

    logic            r_out_vld;
    t_status         r_out_status;
    logic [ID_W-1:0] r_out_id;

    logic [6:0]        w_sec7;
    logic [SEC_W-1:0]  w_qsec;
    logic [CNT_W-1:0]  w_qn;
    logic [ADDR_W-1:0] w_qbase;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ID_W-1:0]   w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_more_scan;
    logic              w_more_shift;
    logic              w_emit;

    assign w_sec7  = {4'b0, i_cmd.sec};
    assign w_qsec  = w_sec7[SEC_W-1:0];
    assign w_qn    = r_cnt[w_qsec];
    assign w_qbase = ADDR_W'(w_qsec) * ADDR_W'(STACK_DEPTH);

    assign w_more_scan  = ((CNT_W+1)'(r_idx) + (CNT_W+1)'(1)) < (CNT_W+1)'(r_n);
    assign w_more_shift = ((CNT_W+1)'(r_idx) + (CNT_W+1)'(2)) < (CNT_W+1)'(r_n);
    assign w_emit       = (r_state == S_DONE) && (!r_out_vld || o_out.ready);

    assign o_ready        = r_state == S_IDLE;
    assign o_out.valid    = r_out_vld;
    assign o_out.status   = r_out_status;
    assign o_out.found_id = r_out_id;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_qbase + ADDR_W'(w_qn);
        w_wdata = i_cmd.id;
        w_raddr = r_base + ADDR_W'(r_idx);
        case (r_state)
            S_IDLE: begin
                w_we = i_valid && i_cmd.op == OP_STORE && i_cmd.sec_ok
                    && w_qn < CNT_W'(STACK_DEPTH);
            end
            S_SH_RD: begin
                w_raddr = r_base + ADDR_W'(r_idx) + ADDR_W'(1);
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_base + ADDR_W'(r_idx);
                w_wdata = r_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_out_status <= ST_STORED;
            r_out_id     <= '0;
            r_status     <= ST_STORED;
            r_found      <= '0;
            for (int k = 0; k < NUM_SECTIONS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (w_emit) begin
                r_out_vld    <= 1'b1;
                r_out_status <= r_status;
                r_out_id     <= r_found;
            end else if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sec   <= w_qsec;
                        r_base  <= w_qbase;
                        r_n     <= w_qn;
                        r_id    <= i_cmd.id;
                        r_idx   <= IDX_W'(w_qn - CNT_W'(1));
                        r_found <= '0;
                        if (i_cmd.op == OP_STORE) begin
                            r_state <= S_DONE;
                            if (w_we) begin
                                r_cnt[w_qsec] <= w_qn + CNT_W'(1);
                                r_status      <= ST_STORED;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end else if (!i_cmd.sec_ok || w_qn == '0) begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (r_rdata == r_id) begin
                        if (w_more_scan) begin
                            r_state <= S_SH_RD;
                        end else begin
                            r_cnt[r_sec] <= r_n - CNT_W'(1);
                            r_status     <= ST_FOUND;
                            r_found      <= r_id;
                            r_state      <= S_DONE;
                        end
                    end else if (r_idx == '0) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= r_idx - IDX_W'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (w_more_shift) begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_SH_RD;
                    end else begin
                        r_cnt[r_sec] <= r_n - CNT_W'(1);
                        r_status     <= ST_FOUND;
                        r_found      <= r_id;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/keyed_multi_stack_store.sv]
// Keyed multi-stack store, top level.
// Depends on kms_pkg, kms_if, kms_front, kms_fifo and kms_back.
//
// Requests arrive on i_in (operation, section, package_id) and each gives
// exactly one result on o_out (status, found_id), in request order. A
// transfer happens at a rising edge with valid and ready both high.
// A store pushes package_id on the addressed section stack, or reports
// full. A retrieve removes the topmost matching entry and closes the gap.
// With the engine idle, a store or an empty or out-of-range retrieve
// passes through the front register, the queue and the engine's S_DONE
// state into the result register. A retrieve scans from the top through
// the entry memory (registered read), with a read and a compare state per
// entry, then shifts the entries above the match down by a read and a write.
// The stack engine handles one request at a time; a registered front end
// and a two-entry queue keep accepting requests meanwhile until they fill.
// If o_out stalls, the result register holds and the engine waits before
// its next request, so nothing is lost.
// Reset (synchronous, active low) empties every stack at once; entry
// memory needs no clearing.
module keyed_multi_stack_store import kms_pkg::*; #(
    parameter int NUM_SECTIONS = 8,
    parameter int STACK_DEPTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kms_in_if.sink    i_in,
    kms_out_if.source o_out
);

    logic w_f_valid;
    t_cmd w_f_cmd;
    logic w_f_ready;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_ready;

    kms_front #(
        .NUM_SECTIONS (NUM_SECTIONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .o_cmd   (w_f_cmd),
        .i_ready (w_f_ready)
    );

    kms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_cmd   (w_f_cmd),
        .o_ready (w_f_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_ready (w_q_ready)
    );

    kms_back #(
        .NUM_SECTIONS (NUM_SECTIONS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_ready (w_q_ready),
        .o_out   (o_out)
    );

endmodule
